// ===== rtl/cmf_pkg.sv =====
package cmf_pkg;

   // command queue between front and back
   localparam int CmdDepth = 4;
   localparam int CmdPtrW  = $clog2(CmdDepth);

   // CRC-8 generator, MSB first
   localparam logic [7:0] CrcPoly = 8'h31;

   // output sequence positions within one command
   localparam logic [2:0] StepSvc   = 3'd0;
   localparam logic [2:0] StepLenLo = 3'd1;
   localparam logic [2:0] StepLenHi = 3'd2;
   localparam logic [2:0] StepData  = 3'd3;
   localparam logic [2:0] StepCrc   = 3'd4;

   typedef enum logic [1:0] {
      CMD_REJECT = 2'd0,
      CMD_FIRST  = 2'd1,
      CMD_MIDDLE = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   svc;
      logic [15:0]  len;
      logic [7:0]   data;
      logic         last;
   } cmd_type;

   // one byte through the CRC register, eight shift steps
   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/cmf_stream_if.sv =====
interface cmf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [15:0] payload_length;

   modport source (output valid, output data_byte, output payload_length, input ready);
   modport sink   (input valid, input data_byte, input payload_length, output ready);
endinterface

interface cmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic       status;

   modport source (output valid, output out_byte, output frame_end, output status, input ready);
   modport sink   (input valid, input out_byte, input frame_end, input status, output ready);
endinterface

// ===== rtl/cmf_front.sv =====
module cmf_front
   import cmf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cmf_req_if.sink    req_if,
   input  logic [7:0] service_code,
   input  logic       queue_full,
   output logic       push,
   output cmd_type    push_cmd
);

   logic [15:0] remaining_ff, remaining_in;

   assign req_if.ready = !queue_full;
   assign push         = req_if.valid && !queue_full;

   // classify the request against the open message
   always_comb begin
      remaining_in  = remaining_ff;
      push_cmd.svc  = service_code;
      push_cmd.len  = req_if.payload_length;
      push_cmd.data = req_if.data_byte;
      if (remaining_ff == 16'd0) begin
         if (req_if.payload_length == 16'd0) begin
            push_cmd.kind = CMD_REJECT;
            push_cmd.last = 1'b1;
         end else begin
            push_cmd.kind = CMD_FIRST;
            push_cmd.last = (req_if.payload_length == 16'd1);
            remaining_in  = req_if.payload_length - 16'd1;
         end
      end else begin
         push_cmd.kind = CMD_MIDDLE;
         push_cmd.last = (remaining_ff == 16'd1);
         remaining_in  = remaining_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 16'd0;
      end else if (push) begin
         remaining_ff <= remaining_in;
      end
   end

endmodule

// ===== rtl/cmf_queue.sv =====
module cmf_queue
   import cmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type            entry_ff [CmdDepth];
   logic [CmdPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CmdPtrW:0]   count_ff, count_in;

   assign full  = (count_ff == (CmdPtrW + 1)'(CmdDepth)) ? 1'b1 : 1'b0;
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !(pop && !empty)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop && !empty) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage, no reset on payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/cmf_back.sv =====
module cmf_back
   import cmf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  cmd_type  head,
   output logic     pop,
   cmf_rsp_if.source rsp_if
);

   logic [2:0] step_ff, step_in, eff_step;
   logic [7:0] crc_ff, crc_in;
   logic       rsp_valid_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       frame_end_ff, frame_end_in;
   logic       status_ff, status_in;
   logic       load, done;

   assign load = !empty && (!rsp_valid_ff || rsp_if.ready);
   assign pop  = load && done;

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_byte  = out_byte_ff;
   assign rsp_if.frame_end = frame_end_ff;
   assign rsp_if.status    = status_ff;

   // middle bytes start at the data position
   assign eff_step = step_ff + ((head.kind == CMD_MIDDLE) ? StepData : StepSvc);

   // pick the byte for this step and advance the CRC
   always_comb begin
      out_byte_in  = 8'd0;
      frame_end_in = 1'b0;
      status_in    = 1'b0;
      crc_in       = crc_ff;
      done         = 1'b0;
      if (head.kind == CMD_REJECT) begin
         status_in = 1'b1;
         done      = 1'b1;
      end else begin
         case (eff_step)
            StepSvc: begin
               out_byte_in = head.svc;
               crc_in      = crc8_feed(8'd0, head.svc);
            end
            StepLenLo: begin
               out_byte_in = head.len[7:0];
               crc_in      = crc8_feed(crc_ff, head.len[7:0]);
            end
            StepLenHi: begin
               out_byte_in = head.len[15:8];
               crc_in      = crc8_feed(crc_ff, head.len[15:8]);
            end
            StepData: begin
               out_byte_in = head.data;
               crc_in      = crc8_feed(crc_ff, head.data);
               done        = !head.last;
            end
            StepCrc: begin
               out_byte_in  = crc_ff;
               frame_end_in = 1'b1;
               crc_in       = 8'd0;
               done         = 1'b1;
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end
      step_in = done ? 3'd0 : step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         crc_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            step_ff      <= step_in;
            crc_ff       <= crc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff  <= out_byte_in;
         frame_end_ff <= frame_end_in;
         status_ff    <= status_in;
      end
   end

endmodule

// ===== rtl/crc8_message_framer.sv =====
// Channel   Dir  Payload                              Handshake
// req_if    in   data_byte[7:0], payload_length[15:0] valid/ready
// rsp_if    out  out_byte[7:0], frame_end, status     valid/ready
// csr_*     in   csr_write_data[7:0] (service code)   csr_write_enable
//
// Requests are taken one per cycle while the four-entry command queue has room.
// The back end emits one byte per cycle while rsp_if is ready: a first request gives
// service code, length low and high and data, others only data, a last adds the CRC,
// and a reject one status byte; the single registered output byte bounds the rate.
// Reset (synchronous) empties the queue, closes any open message, zeroes the CRC.
// A stalled rsp_if holds the output register; requests continue until the queue fills.
module crc8_message_framer
   import cmf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cmf_req_if.sink    req_if,
   cmf_rsp_if.source  rsp_if,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic [7:0] service_code_ff;
   logic       push, pop, full, empty;
   cmd_type    push_cmd, head;

   // service code register
   always_ff @(posedge clock) begin
      if (reset) begin
         service_code_ff <= 8'd0;
      end else if (csr_write_enable) begin
         service_code_ff <= csr_write_data;
      end
   end

   cmf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .service_code (service_code_ff),
      .queue_full   (full),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   cmf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   cmf_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

// ===== dv/crc8_message_framer_tb.sv =====
`timescale 1ns / 100ps

module crc8_message_framer_tb;

   localparam logic [7:0] FramePoly   = 8'h31;
   localparam logic       StatusOk     = 1'b0;
   localparam logic       StatusReject = 1'b1;
   localparam int         DrainCycles  = 12;
   localparam int         CycleLimit   = 1_000_000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       status;
   } framed_byte_type;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   // one row: a request, or a service code write (value in data)
   typedef struct packed {
      row_kind_type    kind;
      logic [7:0]      data;
      logic [15:0]     len;
      logic            pinned;
      framed_byte_type pin;
   } stim_row_type;

   // pinned rows carry the first framed byte as worked out by hand
   localparam stim_row_type Directed [17] = '{
      // zero length straight after reset: rejected
      '{ROW_REQ, 8'hA5, 16'h0000, 1'b1, '{8'h00, 1'b0, StatusReject}},
      // one-byte message, header carries the reset service code
      '{ROW_REQ, 8'h00, 16'h0001, 1'b1, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'hFF, 16'h0002, 1'b1, '{8'h00, 1'b0, StatusOk}},
      // zero length on a later byte is ignored
      '{ROW_REQ, 8'h00, 16'h0000, 1'b0, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'h3C, 16'h0003, 1'b1, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'hFF, 16'hFFFF, 1'b0, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'h00, 16'h0000, 1'b0, '{8'h00, 1'b0, StatusOk}},
      '{ROW_CSR, 8'hFF, 16'h0000, 1'b0, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'h00, 16'h0000, 1'b1, '{8'h00, 1'b0, StatusReject}},
      '{ROW_REQ, 8'hFF, 16'h0001, 1'b1, '{8'hFF, 1'b0, StatusOk}},
      '{ROW_REQ, 8'h81, 16'h0004, 1'b1, '{8'hFF, 1'b0, StatusOk}},
      // service code changed while a message is open
      '{ROW_CSR, 8'h00, 16'h0000, 1'b0, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'h7E, 16'hAAAA, 1'b0, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'h11, 16'h5555, 1'b0, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'h22, 16'h0000, 1'b0, '{8'h00, 1'b0, StatusOk}},
      // new code shows at the next header
      '{ROW_REQ, 8'h33, 16'h0001, 1'b1, '{8'h00, 1'b0, StatusOk}},
      '{ROW_REQ, 8'hC3, 16'h0000, 1'b1, '{8'h00, 1'b0, StatusReject}}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   cmf_req_if req_if ();
   cmf_rsp_if rsp_if ();

   // pinned first result travels with the request
   logic            req_pinned;
   framed_byte_type req_pin;

   int unsigned req_gap_pct;
   int unsigned rsp_stall_pct;
   bit          mismatch_seen;

   // predictor state
   logic [7:0]      svc_code;
   logic [7:0]      crc_acc;
   logic [15:0]     open_count;
   framed_byte_type expected_frame [$];

   crc8_message_framer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) begin
         r = {r[6:0], 1'b0} ^ (r[7] ? FramePoly : 8'h00);
      end
      return r;
   endfunction

   task automatic push_frame_byte(input logic [7:0] b);
      crc_acc = crc8_step(crc_acc, b);
      expected_frame.push_back('{b, 1'b0, StatusOk});
   endtask

   // expected framed bytes for one accepted request
   task automatic frame_request(input logic [7:0] data, input logic [15:0] len);
      if (open_count == 16'd0) begin
         if (len == 16'd0) begin
            expected_frame.push_back('{8'h00, 1'b0, StatusReject});
            return;
         end
         crc_acc = 8'h00;
         push_frame_byte(svc_code);
         push_frame_byte(len[7:0]);
         push_frame_byte(len[15:8]);
         open_count = len;
      end
      push_frame_byte(data);
      open_count = open_count - 16'd1;
      if (open_count == 16'd0) begin
         expected_frame.push_back('{crc_acc, 1'b1, StatusOk});
         crc_acc = 8'h00;
      end
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_if.ready = ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // predict on accepted requests, check accepted results
   always @(posedge clock) begin
      framed_byte_type got;
      framed_byte_type want;
      int unsigned     slot;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            slot = expected_frame.size();
            frame_request(req_if.data_byte, req_if.payload_length);
            if (req_pinned) begin
               expected_frame[slot] = req_pin;
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.out_byte, rsp_if.frame_end, rsp_if.status};
            if (expected_frame.size() == 0) begin
               $error("unexpected result: out_byte %02h frame_end %0b status %0b",
                      got.out_byte, got.frame_end, got.status);
               mismatch_seen = 1'b1;
            end else begin
               want = expected_frame.pop_front();
               if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                  mismatch_seen = 1'b1;
               end
               if (got.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                  mismatch_seen = 1'b1;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, got.status);
                  mismatch_seen = 1'b1;
               end
            end
         end
      end
   end

   // one request, with random sender gaps in front of it
   task automatic send_request(input logic [7:0] data, input logic [15:0] len,
                               input logic pinned, input framed_byte_type pin);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_if.valid = 1'b0;
         req_pinned   = 1'b0;
         @(negedge clock);
      end
      req_if.valid          = 1'b1;
      req_if.data_byte      = data;
      req_if.payload_length = len;
      req_pinned            = pinned;
      req_pin               = pin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // idle: every result out, then let the back end settle
   task automatic wait_quiet();
      req_if.valid = 1'b0;
      req_pinned   = 1'b0;
      while (expected_frame.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_service_code(input logic [7:0] code);
      csr_write_data   = code;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      svc_code         = code;
   endtask

   // mostly well-formed messages with random content, some rejects
   task automatic run_traffic(input int unsigned n_items);
      logic [7:0]  data;
      logic [15:0] len;
      int unsigned roll;
      for (int unsigned n = 0; n < n_items; n++) begin
         roll = $urandom_range(0, 99);
         data = (roll < 5) ? 8'h00 : (roll < 10) ? 8'hFF : 8'($urandom_range(0, 255));
         roll = $urandom_range(0, 99);
         if (open_count == 16'd0) begin
            if (roll < 12)
               len = 16'd0;
            else if (roll < 80)
               len = 16'($urandom_range(1, 8));
            else
               len = 16'($urandom_range(9, 40));
         end else begin
            len = (roll < 10) ? 16'h0000 : 16'($urandom_range(0, 16'hFFFF));
         end
         send_request(data, len, 1'b0, '0);
      end
   endtask

   // run limit
   initial begin
      for (int c = 0; c < CycleLimit; c++) @(posedge clock);
      $display("crc8_message_framer: mismatch");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_write_data        = 8'h00;
      req_if.valid          = 1'b0;
      req_if.data_byte      = 8'h00;
      req_if.payload_length = 16'h0000;
      rsp_if.ready          = 1'b0;
      req_pinned            = 1'b0;
      req_pin               = '0;
      req_gap_pct           = 0;
      rsp_stall_pct         = 0;
      mismatch_seen         = 1'b0;
      svc_code              = 8'h00;
      crc_acc               = 8'h00;
      open_count            = 16'h0000;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed table, no idling
      foreach (Directed[i]) begin
         if (Directed[i].kind == ROW_CSR) begin
            wait_quiet();
            write_service_code(Directed[i].data);
         end else begin
            send_request(Directed[i].data, Directed[i].len, Directed[i].pinned,
                         Directed[i].pin);
         end
      end

      // no idling: mixed traffic
      wait_quiet();
      write_service_code(8'($urandom_range(0, 255)));
      run_traffic(65);

      // sender idles
      wait_quiet();
      write_service_code(8'($urandom_range(0, 255)));
      req_gap_pct   = 61;
      rsp_stall_pct = 0;
      run_traffic(65);

      // receiver stalls
      wait_quiet();
      write_service_code(8'hFF);
      req_gap_pct   = 0;
      rsp_stall_pct = 61;
      run_traffic(65);

      // both sides idle
      wait_quiet();
      write_service_code(8'($urandom_range(0, 255)));
      req_gap_pct   = 33;
      rsp_stall_pct = 33;
      run_traffic(65);

      wait_quiet();
      if (!mismatch_seen) begin
         $display("crc8_message_framer: match");
      end else begin
         $display("crc8_message_framer: mismatch");
      end
      $finish;
   end

endmodule
